// ----- rtl/core/sto_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sto_pkg
// Shared types and constants of the scheduled tone overlay: the word that is
// queued between front and back, control codes and the sine coefficients.
// ----------------------------------------------------------------------------
package sto_pkg;

    // configuration port
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 15;
    localparam logic [CFG_INDEX_W-1:0] CFG_NOTE_COUNT     = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_TONE_AMPLITUDE = 1'b1;
    localparam logic [3:0]  NOTE_COUNT_RESET = 4'd0;
    localparam logic [14:0] AMP_RESET        = 15'd2000;

    // command codes
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_LOAD   = 1'b1;

    // polynomial sine coefficients, q15
    localparam logic [15:0] SIN_A = 16'd51472;
    localparam logic [15:0] SIN_B = 16'd21167;
    localparam logic [15:0] SIN_C = 16'd2611;
    localparam logic [14:0] SIN_MAX = 15'h7fff;

    // depth of the queue between front and back
    localparam logic [1:0] QUEUE_DEPTH = 2'd2;

    typedef struct packed {
        logic               cmd;
        logic signed [15:0] left;
        logic signed [15:0] right;
        logic [2:0]         slot;
        logic [31:0]        start_time;
        logic [31:0]        end_time;
        logic [31:0]        step;
        logic [31:0]        stamp;
    } item_t;

    typedef struct packed {
        logic [1:0] fill;
    } front_stat_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LAST,
        ST_CUR,
        ST_ADV,
        ST_LOOK,
        ST_HIT,
        ST_X2,
        ST_T1,
        ST_T2,
        ST_SIN,
        ST_MAG
    } back_state_t;

endpackage

// ----- rtl/core/scheduled_tone_overlay.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scheduled_tone_overlay
// Stereo stream tone inserter driven by a loaded note schedule.
// ----------------------------------------------------------------------------
// Words enter through a two-entry queue and are executed one at a time by the
// back end. A note load yields no result. For an audio sample, four reads
// go through the single read port of the note tables (first start, last
// end, current note, possibly the next one), and a tone due then takes the
// phase multiply plus five steps of the shared sine multiplier. The input
// side keeps accepting while the back end works and while a result waits to
// be popped, as long as the queue is not full.
// The note tables have no reset; note_count must only cover loaded slots.
module scheduled_tone_overlay #(
    parameter int MAX_NOTES       = 8,
    parameter int SINE_INDEX_BITS = 10
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               push,
    output logic                               full,
    input  logic                               command,
    input  logic signed [15:0]                 left_sample,
    input  logic signed [15:0]                 right_sample,
    input  logic [2:0]                         note_slot,
    input  logic [31:0]                        note_start,
    input  logic [31:0]                        note_end,
    input  logic [31:0]                        note_phase_step,
    output logic                               empty,
    input  logic                               pop,
    output logic signed [15:0]                 left_out,
    output logic signed [15:0]                 right_out,
    output logic                               tone_active,
    output logic                               muted,
    input  logic                               cfg_we,
    input  logic [sto_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [sto_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import sto_pkg::*;

    logic [3:0]  note_count_reg;
    logic [14:0] amp_reg;
    logic        head_valid;
    item_t       head;
    logic        deq;
    front_stat_t front_stat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            note_count_reg <= NOTE_COUNT_RESET;
            amp_reg        <= AMP_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_NOTE_COUNT:     note_count_reg <= cfg_data[3:0];
                CFG_TONE_AMPLITUDE: amp_reg        <= cfg_data[14:0];
                default:
                begin
                end
            endcase
        end
    end

    sto_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .push            (push),
        .full            (full),
        .command         (command),
        .left_sample     (left_sample),
        .right_sample    (right_sample),
        .note_slot       (note_slot),
        .note_start      (note_start),
        .note_end        (note_end),
        .note_phase_step (note_phase_step),
        .deq             (deq),
        .head_valid      (head_valid),
        .head            (head),
        .stat            (front_stat)
    );

    sto_back #(
        .MAX_NOTES       (MAX_NOTES),
        .SINE_INDEX_BITS (SINE_INDEX_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_valid  (head_valid),
        .head        (head),
        .deq         (deq),
        .note_count  (note_count_reg),
        .amplitude   (amp_reg),
        .pop         (pop),
        .empty       (empty),
        .left_out    (left_out),
        .right_out   (right_out),
        .tone_active (tone_active),
        .muted       (muted)
    );

    // queue never overfills
    a_queue_fill : assert property (@(posedge clk) disable iff (!rst_n)
        front_stat.fill <= QUEUE_DEPTH)
        else $error("front queue fill out of range");

    // a full queue must have had a word waiting the cycle before
    a_full_held : assert property (@(posedge clk) disable iff (!rst_n)
        full |-> $past(front_stat.fill) != 2'd0)
        else $error("queue became full from empty in one cycle");

    // a tone word carries the same value on both channels
    a_tone_mono : assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && tone_active) |-> (left_out == right_out))
        else $error("tone differs between channels");

    // a muted word without tone is silent
    a_mute_zero : assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && muted && !tone_active) |-> (left_out == 16'sd0 && right_out == 16'sd0))
        else $error("muted word is not silent");

endmodule

// ----- rtl/core/sto_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sto_front
// Input side: accepts words, stamps audio words with the saturating sample
// counter and holds them in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module sto_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic                 command,
    input  logic signed [15:0]   left_sample,
    input  logic signed [15:0]   right_sample,
    input  logic [2:0]           note_slot,
    input  logic [31:0]          note_start,
    input  logic [31:0]          note_end,
    input  logic [31:0]          note_phase_step,
    input  logic                 deq,
    output logic                 head_valid,
    output sto_pkg::item_t       head,
    output sto_pkg::front_stat_t stat
);
    import sto_pkg::*;

    item_t       q_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  fill_reg;
    logic [31:0] counter_reg;
    logic        enq;
    logic        do_deq;
    item_t       item_in;

    assign full       = (fill_reg == QUEUE_DEPTH);
    assign head_valid = (fill_reg != 2'd0);
    assign head       = q_reg[rd_ptr_reg];
    assign stat.fill  = fill_reg;
    assign enq        = push && !full;
    assign do_deq     = deq && head_valid;

    always_comb
    begin
        item_in.cmd        = command;
        item_in.left       = left_sample;
        item_in.right      = right_sample;
        item_in.slot       = note_slot;
        item_in.start_time = note_start;
        item_in.end_time   = note_end;
        item_in.step       = note_phase_step;
        item_in.stamp      = counter_reg;
    end

    always_ff @(posedge clk)
    begin
        if (enq)
        begin
            q_reg[wr_ptr_reg] <= item_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg  <= 1'b0;
            rd_ptr_reg  <= 1'b0;
            fill_reg    <= 2'd0;
            counter_reg <= 32'd0;
        end
        else
        begin
            if (enq)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_deq)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            fill_reg <= fill_reg + {1'b0, enq} - {1'b0, do_deq};
            // counter stops at its maximum
            if (enq && command == CMD_SAMPLE && counter_reg != 32'hffff_ffff)
            begin
                counter_reg <= counter_reg + 32'd1;
            end
        end
    end

endmodule

// ----- rtl/core/sto_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sto_back
// Execution side: note tables, mute window, current-note tracking, the
// shared-multiplier sine chain and the result register.
// ----------------------------------------------------------------------------
module sto_back #(
    parameter int MAX_NOTES       = 8,
    parameter int SINE_INDEX_BITS = 10
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               head_valid,
    input  sto_pkg::item_t     head,
    output logic               deq,
    input  logic [3:0]         note_count,
    input  logic [14:0]        amplitude,
    input  logic               pop,
    output logic               empty,
    output logic signed [15:0] left_out,
    output logic signed [15:0] right_out,
    output logic               tone_active,
    output logic               muted
);
    import sto_pkg::*;

    localparam int IDX_W   = (MAX_NOTES > 1) ? $clog2(MAX_NOTES) : 1;
    localparam int CUR_W   = $clog2(MAX_NOTES + 1);
    localparam int QB      = SINE_INDEX_BITS - 2;
    localparam int X_SHIFT = 15 - QB;
    localparam logic [QB:0] QSIZE = {1'b1, {QB{1'b0}}};

    back_state_t state_reg;
    back_state_t state_next;

    // note tables
    logic [31:0] start_mem [MAX_NOTES];
    logic [31:0] end_mem   [MAX_NOTES];
    logic [31:0] step_mem  [MAX_NOTES];
    logic [31:0] start_rd_reg;
    logic [31:0] end_rd_reg;
    logic [31:0] step_rd_reg;
    logic [IDX_W-1:0] rd_addr;
    logic [IDX_W-1:0] wr_addr;
    logic             mem_we;

    logic [CUR_W-1:0] n_c;
    logic [CUR_W-1:0] cur_reg;
    logic [CUR_W-1:0] cur_clamp;
    logic             adv_c;
    logic             hit_c;
    logic             take_sample;

    logic [31:0] t_reg;
    logic [15:0] left_reg;
    logic [15:0] right_reg;
    logic [31:0] start0_reg;
    logic        muted_reg;
    logic [31:0] phase_reg;
    logic [1:0]  quad_reg;
    logic [15:0] x_reg;
    logic [15:0] x2_reg;
    logic [15:0] poly_reg;

    // sine path
    logic [SINE_INDEX_BITS-1:0] sidx;
    logic [1:0]                 squad;
    logic [QB-1:0]              spos;
    logic [QB:0]                spos_m;
    logic [15:0]                x_c;
    logic [15:0]                mul_a;
    logic [15:0]                mul_b;
    logic [31:0]                mul_p;
    logic [16:0]                s_wide;
    logic [14:0]                s_sat;
    logic [15:0]                mag16;
    logic [15:0]                tone_c;

    logic        out_valid_reg;
    logic        out_free;
    logic        out_load;
    logic        out_tone;

    // notes in use, capped at the table depth
    always_comb
    begin
        if (32'(note_count) > MAX_NOTES)
        begin
            n_c = CUR_W'(MAX_NOTES);
        end
        else
        begin
            n_c = CUR_W'(note_count);
        end
        cur_clamp = (cur_reg > n_c) ? n_c : cur_reg;
    end

    assign adv_c = (cur_reg < n_c) && (t_reg > end_rd_reg);
    assign hit_c = (cur_reg < n_c) && (t_reg > start_rd_reg) && (t_reg < end_rd_reg);

    assign take_sample = (state_reg == ST_IDLE) && head_valid && (head.cmd == CMD_SAMPLE);
    assign mem_we  = (state_reg == ST_IDLE) && head_valid && (head.cmd == CMD_LOAD)
                     && (32'(head.slot) < MAX_NOTES);
    assign wr_addr = IDX_W'(head.slot);

    always_comb
    begin
        case (state_reg)
            ST_IDLE: rd_addr = '0;
            ST_LAST: rd_addr = IDX_W'(n_c - 1'b1);
            default: rd_addr = cur_reg[IDX_W-1:0];
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            start_mem[wr_addr] <= head.start_time;
            end_mem[wr_addr]   <= head.end_time;
            step_mem[wr_addr]  <= head.step;
        end
        start_rd_reg <= start_mem[rd_addr];
        end_rd_reg   <= end_mem[rd_addr];
        step_rd_reg  <= step_mem[rd_addr];
    end

    // sine index split; odd quadrants are mirrored
    always_comb
    begin
        sidx   = phase_reg[31 -: SINE_INDEX_BITS];
        squad  = sidx[SINE_INDEX_BITS-1 -: 2];
        spos   = sidx[QB-1:0];
        spos_m = squad[0] ? (QSIZE - {1'b0, spos}) : {1'b0, spos};
        x_c    = 16'(spos_m) << X_SHIFT;
    end

    // one multiplier shared by the polynomial steps and the amplitude scaling
    always_comb
    begin
        case (state_reg)
            ST_X2:
            begin
                mul_a = x_c;
                mul_b = x_c;
            end
            ST_T1:
            begin
                mul_a = x2_reg;
                mul_b = SIN_C;
            end
            ST_T2:
            begin
                mul_a = x2_reg;
                mul_b = poly_reg;
            end
            ST_SIN:
            begin
                mul_a = x_reg;
                mul_b = poly_reg;
            end
            default:
            begin
                mul_a = {1'b0, amplitude};
                mul_b = poly_reg;
            end
        endcase
        mul_p  = 32'(mul_a) * 32'(mul_b);
        s_wide = mul_p[31:15];
        s_sat  = (s_wide > 17'(SIN_MAX)) ? SIN_MAX : s_wide[14:0];
        mag16  = {1'b0, mul_p[29:15]};
        tone_c = quad_reg[1] ? (16'd0 - mag16) : mag16;
    end

    assign out_free = !out_valid_reg || pop;

    always_comb
    begin
        state_next = state_reg;
        deq        = 1'b0;
        out_load   = 1'b0;
        out_tone   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (head_valid)
                begin
                    deq = 1'b1;
                    if (head.cmd == CMD_SAMPLE)
                    begin
                        state_next = ST_LAST;
                    end
                end
            end
            ST_LAST: state_next = ST_CUR;
            ST_CUR:  state_next = ST_ADV;
            ST_ADV:  state_next = ST_LOOK;
            ST_LOOK: state_next = ST_HIT;
            ST_HIT:
            begin
                if (hit_c)
                begin
                    state_next = ST_X2;
                end
                else if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_X2:  state_next = ST_T1;
            ST_T1:  state_next = ST_T2;
            ST_T2:  state_next = ST_SIN;
            ST_SIN: state_next = ST_MAG;
            ST_MAG:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    out_tone   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cur_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_load || (out_valid_reg && !pop);
            if (take_sample)
            begin
                cur_reg <= cur_clamp;
            end
            else if (state_reg == ST_ADV && adv_c)
            begin
                cur_reg <= cur_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                t_reg     <= head.stamp;
                left_reg  <= head.left;
                right_reg <= head.right;
            end
            ST_LAST: start0_reg <= start_rd_reg;
            ST_CUR:
            begin
                // inside the window from first start to last end
                muted_reg <= (n_c != '0) && (t_reg > start0_reg) && (t_reg < end_rd_reg);
            end
            ST_HIT: phase_reg <= t_reg * step_rd_reg;
            ST_X2:
            begin
                x_reg    <= x_c;
                quad_reg <= squad;
                x2_reg   <= mul_p[30:15];
            end
            ST_T1:  poly_reg <= SIN_B - mul_p[30:15];
            ST_T2:  poly_reg <= SIN_A - mul_p[30:15];
            ST_SIN: poly_reg <= {1'b0, s_sat};
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            tone_active <= out_tone;
            muted       <= muted_reg;
            if (out_tone)
            begin
                left_out  <= tone_c;
                right_out <= tone_c;
            end
            else if (muted_reg)
            begin
                left_out  <= 16'sd0;
                right_out <= 16'sd0;
            end
            else
            begin
                left_out  <= left_reg;
                right_out <= right_reg;
            end
        end
    end

    assign empty = !out_valid_reg;

endmodule

// ----- bench/scheduled_tone_overlay_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scheduled_tone_overlay_tb
// Self-checking bench for the tone overlay. A short table of directed words
// (pass-through with no notes, the mute window, note stepping, the index
// bound) is followed by random phases. Each phase writes the registers while
// the block is idle, loads a note schedule placed just ahead of the sample
// counter and then streams samples through it, with stray loads mixed in.
// Samples are predicted by a local model of the mixer or by the directed table,
// and each popped word is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module scheduled_tone_overlay_tb;

    import sto_pkg::*;

    localparam int MAX_NOTES     = 8;
    localparam int SINE_BITS     = 10;
    localparam int WORD_TARGET   = 1200;
    localparam int SETTLE_CYCLES = 40;
    localparam int QUIET_LIMIT   = 5000;

    localparam longint unsigned COEF_A  = 51472;
    localparam longint unsigned COEF_B  = 21167;
    localparam longint unsigned COEF_C  = 2611;
    localparam longint unsigned QUARTER = 1 << (SINE_BITS - 2);

    typedef struct {
        logic               cmd;
        logic signed [15:0] left;
        logic signed [15:0] right;
        logic [2:0]         slot;
        logic [31:0]        t_start;
        logic [31:0]        t_end;
        logic [31:0]        phase_step;
    } word_t;

    typedef struct packed {
        logic signed [15:0] left;
        logic signed [15:0] right;
        logic               tone;
        logic               mute;
    } mix_t;

    typedef enum {ROW_WORD, ROW_REGS} row_kind_t;

    typedef struct {
        row_kind_t   kind;
        word_t       w;
        logic [3:0]  n_notes;
        logic [14:0] amp;
        bit          typed;
        mix_t        want;
    } row_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               push = 1'b0;
    logic               full;
    logic               command = CMD_SAMPLE;
    logic signed [15:0] left_sample = '0;
    logic signed [15:0] right_sample = '0;
    logic [2:0]         note_slot = '0;
    logic [31:0]        note_start = '0;
    logic [31:0]        note_end = '0;
    logic [31:0]        note_phase_step = '0;
    logic               empty;
    logic               pop = 1'b0;
    logic signed [15:0] left_out;
    logic signed [15:0] right_out;
    logic               tone_active;
    logic               muted;
    logic                   cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    scheduled_tone_overlay #(
        .MAX_NOTES       (MAX_NOTES),
        .SINE_INDEX_BITS (SINE_BITS)
    ) uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .push            (push),
        .full            (full),
        .command         (command),
        .left_sample     (left_sample),
        .right_sample    (right_sample),
        .note_slot       (note_slot),
        .note_start      (note_start),
        .note_end        (note_end),
        .note_phase_step (note_phase_step),
        .empty           (empty),
        .pop             (pop),
        .left_out        (left_out),
        .right_out       (right_out),
        .tone_active     (tone_active),
        .muted           (muted),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // mixer model state
    logic [31:0] smp_count = '0;
    int unsigned note_idx = 0;
    logic [3:0]  sched_len = NOTE_COUNT_RESET;
    logic [14:0] tone_amp = AMP_RESET;
    logic [31:0] tbl_start [MAX_NOTES];
    logic [31:0] tbl_end [MAX_NOTES];
    logic [31:0] tbl_step [MAX_NOTES];

    mix_t        expected_mix_q [$];
    row_t        directed_rows [$];
    int          mismatch_count = 0;
    int          words_sent = 0;
    int unsigned burst_left = 0;
    int          quiet_cycles = 0;
    mix_t        want_mix;

    function automatic logic signed [15:0] sine_tone(input logic [31:0] phase,
                                                     input logic [14:0] amp);
        logic [SINE_BITS-1:0] idx;
        logic [1:0]           quad;
        longint unsigned      pos, x, x2, poly, s, mag;
        idx  = phase[31 -: SINE_BITS];
        quad = idx[SINE_BITS-1 -: 2];
        pos  = idx[SINE_BITS-3:0];
        // odd quadrants run the quarter wave backwards
        if (quad[0])
            pos = QUARTER - pos;
        x    = (pos << 15) >> (SINE_BITS - 2);
        x2   = (x * x) >> 15;
        poly = COEF_B - ((x2 * COEF_C) >> 15);
        poly = COEF_A - ((x2 * poly) >> 15);
        s    = (x * poly) >> 15;
        if (s > 32767)
            s = 32767;
        mag = (longint'(amp) * s) >> 15;
        return quad[1] ? 16'(0 - mag) : 16'(mag);
    endfunction

    // returns 1 when the word yields an output word
    function automatic bit mix_word(input word_t w, output mix_t r);
        int unsigned n;
        logic [31:0] ts;
        logic [31:0] phase;
        r = '0;
        if (w.cmd == CMD_LOAD)
        begin
            if (w.slot < MAX_NOTES)
            begin
                tbl_start[w.slot] = w.t_start;
                tbl_end[w.slot]   = w.t_end;
                tbl_step[w.slot]  = w.phase_step;
            end
            return 1'b0;
        end
        n = (sched_len > MAX_NOTES) ? MAX_NOTES : sched_len;
        ts = smp_count;
        r.left  = w.left;
        r.right = w.right;
        if (note_idx > n)
            note_idx = n;
        if (n > 0 && ts > tbl_start[0] && ts < tbl_end[n-1])
        begin
            r.mute  = 1'b1;
            r.left  = '0;
            r.right = '0;
        end
        if (note_idx < n && ts > tbl_end[note_idx])
            note_idx++;
        if (note_idx < n && ts > tbl_start[note_idx] && ts < tbl_end[note_idx])
        begin
            phase   = ts * tbl_step[note_idx];
            r.tone  = 1'b1;
            r.left  = sine_tone(phase, tone_amp);
            r.right = r.left;
        end
        if (smp_count != '1)
            smp_count++;
        return 1'b1;
    endfunction

    function automatic row_t row_typed(input logic signed [15:0] l, r, wl, wr,
                                       input logic tone, mute);
        row_t row;
        row = '{kind: ROW_WORD, default: '0};
        row.kind   = ROW_WORD;
        row.w.cmd  = CMD_SAMPLE;
        row.w.left = l;
        row.w.right = r;
        row.typed  = 1'b1;
        row.want   = '{wl, wr, tone, mute};
        return row;
    endfunction

    function automatic row_t row_sample(input logic signed [15:0] l, r);
        row_t row;
        row = row_typed(l, r, '0, '0, 1'b0, 1'b0);
        row.typed = 1'b0;
        return row;
    endfunction

    function automatic row_t row_load(input logic [2:0] slot,
                                      input logic [31:0] s, e, st);
        row_t row;
        row = '{kind: ROW_WORD, default: '0};
        row.kind         = ROW_WORD;
        row.w.cmd        = CMD_LOAD;
        row.w.slot       = slot;
        row.w.t_start    = s;
        row.w.t_end      = e;
        row.w.phase_step = st;
        return row;
    endfunction

    function automatic row_t row_regs(input logic [3:0] n, input logic [14:0] amp);
        row_t row;
        row = '{kind: ROW_REGS, default: '0};
        row.kind    = ROW_REGS;
        row.n_notes = n;
        row.amp     = amp;
        return row;
    endfunction

    function automatic logic signed [15:0] pick_sample();
        case ($urandom_range(0, 9))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] pick_wide();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic void check_field(input string what, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
            mismatch_count++;
        end
    endfunction

    task automatic send_word(input word_t w, input bit typed, input mix_t want);
        mix_t        r;
        int unsigned gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 40);
            if (gap != 0)
            begin
                push <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        push            <= 1'b1;
        command         <= w.cmd;
        left_sample     <= w.left;
        right_sample    <= w.right;
        note_slot       <= w.slot;
        note_start      <= w.t_start;
        note_end        <= w.t_end;
        note_phase_step <= w.phase_step;
        do
            @(posedge clk);
        while (full);
        if (mix_word(w, r))
            expected_mix_q.push_back(typed ? want : r);
        words_sent++;
    endtask

    // wait until the block has drained, loads included
    task automatic settle();
        push <= 1'b0;
        while (expected_mix_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_regs(input logic [3:0] n, input logic [14:0] amp);
        settle();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_NOTE_COUNT;
        cfg_data  <= CFG_DATA_W'(n);
        @(posedge clk);
        sched_len = n;
        cfg_index <= CFG_TONE_AMPLITUDE;
        cfg_data  <= amp;
        @(posedge clk);
        tone_amp = amp;
        cfg_we <= 1'b0;
    endtask

    // one schedule placed just ahead of the counter, then samples through it
    task automatic run_phase();
        int unsigned k, span, i;
        logic [31:0] cursor, last_end;
        logic [3:0]  n_cfg;
        logic [14:0] amp;
        word_t       w;
        k = $urandom_range(0, MAX_NOTES);
        case ($urandom_range(0, 5))
            0: n_cfg = '0;
            1: n_cfg = (k != 0) ? 4'($urandom_range(1, k)) : 4'd0;
            default: n_cfg = 4'(k);
        endcase
        // counts above the table size only once every slot is loaded
        if (k == MAX_NOTES && $urandom_range(0, 2) == 0)
            n_cfg = 4'($urandom_range(MAX_NOTES + 1, 15));
        case ($urandom_range(0, 5))
            0: amp = '0;
            1: amp = '1;
            default: amp = 15'($urandom);
        endcase
        write_regs(n_cfg, amp);

        cursor = smp_count + $urandom_range(0, 12);
        last_end = smp_count;
        for (i = 0; i < k; i++)
        begin
            w.cmd        = CMD_LOAD;
            w.left       = pick_sample();
            w.right      = pick_sample();
            w.slot       = 3'(i);
            w.t_start    = cursor + $urandom_range(0, 5);
            w.t_end      = w.t_start + $urandom_range(0, 24);
            w.phase_step = ($urandom_range(0, 9) == 0) ? pick_wide() : $urandom;
            if (w.t_end > last_end)
                last_end = w.t_end;
            cursor = ($urandom_range(0, 9) == 0) ? w.t_start
                                                 : w.t_end + $urandom_range(0, 4);
            send_word(w, 1'b0, '0);
        end

        span = (k == 0) ? $urandom_range(5, 40)
                        : (last_end - smp_count) + $urandom_range(2, 16);
        if (span > 300)
            span = 300;
        for (i = 0; i < span; i++)
        begin
            w.left  = pick_sample();
            w.right = pick_sample();
            w.slot  = 3'($urandom);
            if ($urandom_range(0, 13) == 0)
            begin
                // stray load, may break the schedule in flight
                w.cmd        = CMD_LOAD;
                w.t_start    = pick_wide();
                w.t_end      = pick_wide();
                w.phase_step = pick_wide();
            end
            else
            begin
                w.cmd        = CMD_SAMPLE;
                w.t_start    = $urandom;
                w.t_end      = $urandom;
                w.phase_step = $urandom;
            end
            send_word(w, 1'b0, '0);
        end
    endtask

    // receiver stall pattern, renewed each time pop_tick wraps
    logic [15:0] pop_mask = 16'hffff;
    logic [5:0]  pop_tick = '0;

    always @(posedge clk)
    begin
        pop_tick <= pop_tick + 1'b1;
        pop <= pop_mask[pop_tick[3:0]];
        if (pop_tick == '1)
        begin
            case ($urandom_range(0, 3))
                0: pop_mask <= 16'hffff;
                1: pop_mask <= 16'($urandom) & 16'($urandom) | 16'h0001;
                default: pop_mask <= 16'($urandom) | 16'h0001;
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            if (expected_mix_q.size() == 0)
            begin
                $display("%0t: word popped with nothing expected, got %0d %0d %0b %0b",
                         $time, left_out, right_out, tone_active, muted);
                mismatch_count++;
            end
            else
            begin
                want_mix = expected_mix_q.pop_front();
                check_field("left_out", want_mix.left, left_out);
                check_field("right_out", want_mix.right, right_out);
                check_field("tone_active", want_mix.tone, tone_active);
                check_field("muted", want_mix.mute, muted);
            end
        end
    end

    // watchdog on cycles with no word moving either way
    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("scheduled_tone_overlay_tb NOT OK");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        directed_rows = {
            // no notes in use: samples pass untouched
            row_typed(16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 1'b0, 1'b0),
            row_typed(16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 1'b0, 1'b0),
            row_typed(16'sh0000, 16'shffff, 16'sh0000, 16'shffff, 1'b0, 1'b0),
            row_load(3'd0, 32'd4, 32'd9, 32'h4000_0000),
            row_load(3'd1, 32'd10, 32'd14, 32'h0000_0000),
            row_load(3'd2, 32'd14, 32'hffff_ffff, 32'hffff_ffff),
            row_load(3'd7, 32'hffff_ffff, 32'd0, 32'h5555_aaaa),
            row_regs(4'd3, 15'h7fff),
            // bounds are exclusive
            row_typed(16'sh0064, 16'shff9c, 16'sh0064, 16'shff9c, 1'b0, 1'b0),
            row_typed(16'sh1234, 16'shedcb, 16'sh1234, 16'shedcb, 1'b0, 1'b0),
            row_sample(16'sh1111, 16'sh2222),
            row_sample(16'sh3333, 16'sh4444),
            row_sample(16'sh5555, 16'sh6666),
            row_sample(16'sh7777, 16'sh8888),
            // in the window between notes: muted, no tone
            row_typed(16'sh0101, 16'sh0202, 16'sh0000, 16'sh0000, 1'b0, 1'b1),
            row_typed(16'sh0303, 16'sh0404, 16'sh0000, 16'sh0000, 1'b0, 1'b1),
            // zero phase step gives a silent tone
            row_typed(16'sh0505, 16'sh0606, 16'sh0000, 16'sh0000, 1'b1, 1'b1),
            row_typed(16'sh0707, 16'sh0808, 16'sh0000, 16'sh0000, 1'b1, 1'b1),
            row_typed(16'sh0909, 16'sh0a0a, 16'sh0000, 16'sh0000, 1'b1, 1'b1),
            row_typed(16'sh0b0b, 16'sh0c0c, 16'sh0000, 16'sh0000, 1'b0, 1'b1),
            row_sample(16'sh7fff, 16'sh7fff),
            row_sample(16'sh8000, 16'sh8000),
            row_regs(4'd0, 15'h7fff),
            row_typed(16'sh4321, 16'shbcde, 16'sh4321, 16'shbcde, 1'b0, 1'b0),
            // index steps by one per sample, zero amplitude
            row_regs(4'd3, 15'h0000),
            row_typed(16'sh0d0d, 16'sh0e0e, 16'sh0000, 16'sh0000, 1'b0, 1'b1),
            row_typed(16'sh0f0f, 16'sh1010, 16'sh0000, 16'sh0000, 1'b1, 1'b1),
            // last note over: index sits at the note count
            row_load(3'd2, 32'd14, 32'd19, 32'hffff_ffff),
            row_typed(16'sh2468, 16'sh1357, 16'sh2468, 16'sh1357, 1'b0, 1'b0)
        };

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_REGS)
                write_regs(directed_rows[i].n_notes, directed_rows[i].amp);
            else
                send_word(directed_rows[i].w, directed_rows[i].typed,
                          directed_rows[i].want);
        end

        while (words_sent < WORD_TARGET)
            run_phase();

        settle();
        if (mismatch_count == 0 && expected_mix_q.size() == 0)
            $display("scheduled_tone_overlay_tb OK");
        else
            $display("scheduled_tone_overlay_tb NOT OK");
        $finish;
    end

endmodule
